// File: src/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg : shared definitions for the sparse matrix-vector block
// Widths, request codes, error codes, register indexes and the controller
// state type.
// ----------------------------------------------------------------------------
`default_nettype none

package csm_pkg;

    // Default vector store depth
    localparam int MAX_DIM_DEF = 1024;

    // Field widths
    localparam int ACT_W     = 3;
    localparam int POS_W     = 10;
    localparam int DATA_W    = 32;
    localparam int ROW_W     = 10;
    localparam int ERR_W     = 2;
    localparam int CNT_W     = 11;
    localparam int CFG_IDX_W = 3;

    // Request codes
    localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BEGIN   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ENTRY   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_END     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESTART = 3'd4;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SHIFT = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd4;

    // Reset values
    localparam logic [DATA_W-1:0] ALPHA_RST = 32'h0001_0000;
    localparam logic [CNT_W-1:0]  DIM_RST   = 11'd1024;
    localparam logic [CNT_W-1:0]  ROW_LIMIT = 11'd2047;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENT_MUL,
        ST_ENT_ACC,
        ST_END_A,
        ST_END_B,
        ST_END_C,
        ST_END_D,
        ST_END_E,
        ST_END_F
    } state_t;

endpackage

`default_nettype wire

// File: src/csm_if.sv
// ----------------------------------------------------------------------------
// csm_if : request and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface csm_in_if;
    logic                              valid;
    logic                              ready;
    logic [csm_pkg::ACT_W-1:0]         action;
    logic [csm_pkg::POS_W-1:0]         position;
    logic signed [csm_pkg::DATA_W-1:0] data_value;

    modport source (output valid, output action, output position, output data_value,
                    input ready);
    modport sink   (input valid, input action, input position, input data_value,
                    output ready);
endinterface

interface csm_out_if;
    logic                              valid;
    logic                              ready;
    logic [csm_pkg::ROW_W-1:0]         row_index;
    logic signed [csm_pkg::DATA_W-1:0] y_value;
    logic [csm_pkg::ERR_W-1:0]         error_code;

    modport source (output valid, output row_index, output y_value, output error_code,
                    input ready);
    modport sink   (input valid, input row_index, input y_value, input error_code,
                    output ready);
endinterface

`default_nettype wire

// File: src/csm_ram.sv
// ----------------------------------------------------------------------------
// csm_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/csr_sparse_matvec_shifted.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec_shifted : sparse matrix-vector product, Q16.16
// y = alpha*A*x + beta*y_old + gamma*x[row], rows in compressed row order.
// ----------------------------------------------------------------------------
// Use:
//   Software writes the coefficient and size registers through the plain
//   write port, then loads x with load requests. Each row is a begin request
//   (old y), any number of entry requests (column, value) and an end request.
//   Only the end request produces a result on the output channel.
// Sequence:
//   Load, begin, restart and ignored codes are handled in the idle state.
//   An in-range entry runs a vector store read, a multiply, then the
//   saturating accumulate; the store's registered read and the shared
//   multiplier set these steps. An out-of-range entry stays in idle.
//   An end request runs a store read of x[row], four passes through the
//   shared 33x33 multiplier, then two summing steps; the last step loads the
//   result into the output register.
// Stalls and reset:
//   The output register holds a result until taken; idle requests, a row
//   end among them, are accepted meanwhile. A row end waits in its last
//   step while the output register is full. Reset clears control state and
//   restores the register reset values; the vector store is not cleared
//   and an entry reads as undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_sparse_matvec_shifted #(
    parameter int MAX_DIM = csm_pkg::MAX_DIM_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [csm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [csm_pkg::DATA_W-1:0]      cfg_data,
    csm_in_if.sink                               in_ch,
    csm_out_if.source                            out_ch
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // Registers
    csm_pkg::state_t state_reg, state_next;
    logic [63:0]     acc_reg, acc_next;
    logic [10:0]     cur_row_reg, cur_row_next;
    logic            fault_reg, fault_next;
    logic [31:0]     y_old_reg, y_old_next;
    logic [31:0]     alpha_reg, alpha_next;
    logic [31:0]     beta_reg, beta_next;
    logic [31:0]     gamma_reg, gamma_next;
    logic [10:0]     col_cnt_reg, col_cnt_next;
    logic [10:0]     row_cnt_reg, row_cnt_next;
    logic [31:0]     data_reg, data_next;
    logic [65:0]     prod_reg, prod_next;
    logic [95:0]     wide_reg, wide_next;
    logic [49:0]     ysum_reg, ysum_next;
    logic [49:0]     tsum_reg, tsum_next;
    logic [1:0]      err_reg, err_next;
    logic            out_valid_reg, out_valid_next;
    logic [9:0]      out_row_reg, out_row_next;
    logic [31:0]     out_y_reg, out_y_next;
    logic [1:0]      out_err_reg, out_err_next;

    // Request decode
    logic        in_fire;
    logic        out_free;
    logic [31:0] pos_ext;
    logic [31:0] row_ext;
    logic        load_ok;
    logic        entry_ok;
    logic        row_ok;

    // Vector store ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    // Shared multiplier
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;

    // Arithmetic helpers
    logic [63:0] acc_sum;
    logic        acc_ovf;
    logic [95:0] wide_biased;
    logic [63:0] prod_biased;
    logic [47:0] t48;
    logic [47:0] t16;
    logic [49:0] y_full;
    logic [31:0] y_sat;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign pos_ext  = 32'(in_ch.position);
    assign row_ext  = 32'(cur_row_reg);
    assign load_ok  = pos_ext < 32'(MAX_DIM);
    assign entry_ok = load_ok && ({1'b0, in_ch.position} < col_cnt_reg);
    assign row_ok   = (cur_row_reg < row_cnt_reg) && (row_ext < 32'(MAX_DIM));

    assign in_ch.ready = (state_reg == csm_pkg::ST_IDLE);

    assign mul_p = mul_a * mul_b;

    // Vector store
    csm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_DIM),
        .AW    (AW)
    ) u_x_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Store port drive
    always_comb
    begin
        ram_waddr = pos_ext[AW-1:0];
        ram_wdata = in_ch.data_value;
        ram_we    = in_fire && (in_ch.action == csm_pkg::ACT_LOAD) && load_ok;
        ram_re    = 1'b0;
        ram_raddr = pos_ext[AW-1:0];
        if (in_fire && (in_ch.action == csm_pkg::ACT_ENTRY) && entry_ok)
        begin
            ram_re = 1'b1;
        end
        else if (in_fire && (in_ch.action == csm_pkg::ACT_END) && row_ok)
        begin
            ram_re    = 1'b1;
            ram_raddr = row_ext[AW-1:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csm_pkg::ST_IDLE:
            begin
                if (in_fire && (in_ch.action == csm_pkg::ACT_ENTRY) && entry_ok)
                begin
                    state_next = csm_pkg::ST_ENT_MUL;
                end
                else if (in_fire && (in_ch.action == csm_pkg::ACT_END))
                begin
                    state_next = csm_pkg::ST_END_A;
                end
            end
            csm_pkg::ST_ENT_MUL: state_next = csm_pkg::ST_ENT_ACC;
            csm_pkg::ST_ENT_ACC: state_next = csm_pkg::ST_IDLE;
            csm_pkg::ST_END_A:   state_next = csm_pkg::ST_END_B;
            csm_pkg::ST_END_B:   state_next = csm_pkg::ST_END_C;
            csm_pkg::ST_END_C:   state_next = csm_pkg::ST_END_D;
            csm_pkg::ST_END_D:   state_next = csm_pkg::ST_END_E;
            csm_pkg::ST_END_E:   state_next = csm_pkg::ST_END_F;
            csm_pkg::ST_END_F:
            begin
                if (out_free)
                begin
                    state_next = csm_pkg::ST_IDLE;
                end
            end
            default:             state_next = csm_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            csm_pkg::ST_ENT_MUL:
            begin
                mul_a = {data_reg[31], data_reg};
                mul_b = {ram_rdata[31], ram_rdata};
            end
            csm_pkg::ST_END_A:
            begin
                mul_a = {alpha_reg[31], alpha_reg};
                mul_b = {1'b0, acc_reg[31:0]};
            end
            csm_pkg::ST_END_B:
            begin
                mul_a = {alpha_reg[31], alpha_reg};
                mul_b = {acc_reg[63], acc_reg[63:32]};
            end
            csm_pkg::ST_END_C:
            begin
                mul_a = {beta_reg[31], beta_reg};
                mul_b = {y_old_reg[31], y_old_reg};
            end
            csm_pkg::ST_END_D:
            begin
                // a zero gamma keeps an unloaded x out of the result
                mul_a = {gamma_reg[31], gamma_reg};
                mul_b = (gamma_reg == '0) ? '0 : {ram_rdata[31], ram_rdata};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Arithmetic helpers
    always_comb
    begin
        // saturating accumulate of an entry product
        acc_sum = acc_reg + prod_reg[63:0];
        acc_ovf = (acc_reg[63] == prod_reg[63]) && (acc_sum[63] != acc_reg[63]);

        // truncation toward zero: bias negative values before the shift
        wide_biased = wide_reg + (wide_reg[95] ? {48'h0, {48{1'b1}}} : 96'h0);
        t48         = wide_biased[95:48];
        prod_biased = prod_reg[63:0] + (prod_reg[63] ? 64'h0000_0000_0000_FFFF : 64'h0);
        t16         = prod_biased[63:16];

        // final sum and 32 bit saturation
        y_full = ysum_reg + tsum_reg;
        if (y_full[49:31] == {19{y_full[49]}})
        begin
            y_sat = y_full[31:0];
        end
        else
        begin
            y_sat = y_full[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // Datapath and output register
    always_comb
    begin
        acc_next       = acc_reg;
        cur_row_next   = cur_row_reg;
        fault_next     = fault_reg;
        y_old_next     = y_old_reg;
        alpha_next     = alpha_reg;
        beta_next      = beta_reg;
        gamma_next     = gamma_reg;
        col_cnt_next   = col_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        data_next      = data_reg;
        prod_next      = prod_reg;
        wide_next      = wide_reg;
        ysum_next      = ysum_reg;
        tsum_next      = tsum_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_y_next     = out_y_reg;
        out_err_next   = out_err_reg;

        // result taken
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                csm_pkg::CFG_ALPHA: alpha_next   = cfg_data;
                csm_pkg::CFG_BETA:  beta_next    = cfg_data;
                csm_pkg::CFG_GAMMA: gamma_next   = cfg_data;
                csm_pkg::CFG_COLS:  col_cnt_next = cfg_data[10:0];
                csm_pkg::CFG_ROWS:  row_cnt_next = cfg_data[10:0];
                default:            ;
            endcase
        end

        case (state_reg)
            csm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_ch.action)
                        csm_pkg::ACT_BEGIN:
                        begin
                            acc_next   = '0;
                            fault_next = 1'b0;
                            y_old_next = in_ch.data_value;
                        end
                        csm_pkg::ACT_ENTRY:
                        begin
                            data_next = in_ch.data_value;
                            if (!entry_ok)
                            begin
                                fault_next = 1'b1;
                            end
                        end
                        csm_pkg::ACT_END:
                        begin
                            if (fault_reg || !row_ok)
                            begin
                                err_next = csm_pkg::ERR_RANGE;
                            end
                            else if ((gamma_reg != '0) && (row_cnt_reg != col_cnt_reg))
                            begin
                                err_next = csm_pkg::ERR_SHIFT;
                            end
                            else
                            begin
                                err_next = csm_pkg::ERR_OK;
                            end
                        end
                        csm_pkg::ACT_RESTART:
                        begin
                            cur_row_next = '0;
                            acc_next     = '0;
                            fault_next   = 1'b0;
                            y_old_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            csm_pkg::ST_ENT_MUL:
            begin
                prod_next = mul_p;
            end
            csm_pkg::ST_ENT_ACC:
            begin
                if (acc_ovf)
                begin
                    acc_next = acc_reg[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                end
                else
                begin
                    acc_next = acc_sum;
                end
            end
            csm_pkg::ST_END_A:
            begin
                prod_next = mul_p;
            end
            csm_pkg::ST_END_B:
            begin
                // low partial product of alpha * accumulator
                wide_next = {{30{prod_reg[65]}}, prod_reg};
                prod_next = mul_p;
            end
            csm_pkg::ST_END_C:
            begin
                // add high partial product, weight 2^32
                wide_next = wide_reg + {prod_reg[63:0], 32'h0};
                prod_next = mul_p;
            end
            csm_pkg::ST_END_D:
            begin
                ysum_next = {{2{t48[47]}}, t48};
                tsum_next = {{2{t16[47]}}, t16};
                prod_next = mul_p;
            end
            csm_pkg::ST_END_E:
            begin
                ysum_next = ysum_reg + tsum_reg;
                tsum_next = {{2{t16[47]}}, t16};
            end
            csm_pkg::ST_END_F:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = cur_row_reg[9:0];
                    out_err_next   = err_reg;
                    out_y_next     = (err_reg == csm_pkg::ERR_OK) ? y_sat : 32'h0;
                    if (cur_row_reg < csm_pkg::ROW_LIMIT)
                    begin
                        cur_row_next = cur_row_reg + 11'd1;
                    end
                    acc_next   = '0;
                    fault_next = 1'b0;
                    y_old_next = '0;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csm_pkg::ST_IDLE;
            acc_reg       <= '0;
            cur_row_reg   <= '0;
            fault_reg     <= 1'b0;
            y_old_reg     <= '0;
            alpha_reg     <= csm_pkg::ALPHA_RST;
            beta_reg      <= '0;
            gamma_reg     <= '0;
            col_cnt_reg   <= csm_pkg::DIM_RST;
            row_cnt_reg   <= csm_pkg::DIM_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cur_row_reg   <= cur_row_next;
            fault_reg     <= fault_next;
            y_old_reg     <= y_old_next;
            alpha_reg     <= alpha_next;
            beta_reg      <= beta_next;
            gamma_reg     <= gamma_next;
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        data_reg    <= data_next;
        prod_reg    <= prod_next;
        wide_reg    <= wide_next;
        ysum_reg    <= ysum_next;
        tsum_reg    <= tsum_next;
        err_reg     <= err_next;
        out_row_reg <= out_row_next;
        out_y_reg   <= out_y_next;
        out_err_reg <= out_err_next;
    end

    // Result channel
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.row_index  = out_row_reg;
    assign out_ch.y_value    = out_y_reg;
    assign out_ch.error_code = out_err_reg;

    // Checks
    a_end_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_ch.action == csm_pkg::ACT_END)) |=> (state_reg == csm_pkg::ST_END_A))
        else $error("row end did not start the result sequence");

    a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == csm_pkg::ST_END_F))
        else $error("result appeared outside the final step");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_err_reg != csm_pkg::ERR_OK)) |-> (out_y_reg == '0))
        else $error("error result carries a nonzero value");

    a_store_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("vector store written and read in one cycle");

    a_row_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == csm_pkg::ST_END_F) && out_free) |=> ((acc_reg == '0) && !fault_reg))
        else $error("row state not cleared after a result");

endmodule

`default_nettype wire
